// ----- design/two_suitor_graph_matching_assert.svh -----
// Assertion macros for the two-suitor matching block
`ifndef TWO_SUITOR_GRAPH_MATCHING_ASSERT_SVH
`define TWO_SUITOR_GRAPH_MATCHING_ASSERT_SVH

// same-cycle implication, checked outside reset
`define TSGM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define TSGM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/tsgm_pkg.sv -----
// Shared types and constants for the two-suitor matching block
package tsgm_pkg;

   localparam int DEFAULT_MAX_VERTICES = 1024;
   localparam int DEFAULT_MAX_EDGES    = 8192;

   localparam int SLOT_W = 14;
   localparam int VID_W  = 11;
   localparam int WT_W   = 32;
   localparam int ACT_W  = 2;
   localparam int CSR_AW = 3;

   localparam logic [ACT_W-1:0] ACT_ROW  = 2'd0;
   localparam logic [ACT_W-1:0] ACT_EDGE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_RUN  = 2'd2;
   localparam logic [ACT_W-1:0] ACT_READ = 2'd3;

   localparam logic REG_VERTEX_COUNT = 1'b0;
   localparam logic [VID_W-1:0] VERTEX_COUNT_RESET = 11'd1;

   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [SLOT_W-1:0] slot;
      logic [SLOT_W-1:0] row_value;
      logic [VID_W-1:0]  neighbor;
      logic [WT_W-1:0]   edge_weight_in;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [VID_W-1:0]  out_first_suitor;
      logic [WT_W-1:0]   out_first_weight;
      logic [VID_W-1:0]  out_second_suitor;
      logic [WT_W-1:0]   out_second_weight;
   } rsp_type;

   typedef struct packed {
      logic [VID_W-1:0] target;
      logic [WT_W-1:0]  weight;
   } edge_type;

   typedef struct packed {
      logic [VID_W-1:0] best_s;
      logic [WT_W-1:0]  best_w;
      logic [VID_W-1:0] ru_s;
      logic [WT_W-1:0]  ru_w;
   } suitor_type;

   typedef struct packed {
      logic accept;
      logic clr_start;
      logic clr_step;
      logic run_init;
      logic row_rd_lo;
      logic row_rd_hi;
      logic scan_init;
      logic edge_rd;
      logic suit_rd;
      logic eval;
      logic edge_skip;
      logic mate_rd;
      logic mate_wr;
      logic next_prop;
      logic rsp_read;
      logic rsp_run;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic n_zero;
      logic scan_done;
      logic y_ok;
      logic prop_none;
      logic bumped_zero;
      logic run_last;
   } stat_type;

endpackage

// ----- design/tsgm_ram.sv -----
// Generic simple dual-port RAM with registered read
module tsgm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/tsgm_datapath.sv -----
// Datapath: graph and suitor stores, proposal registers, result register
module tsgm_datapath #(
   parameter int MAX_VERTICES = tsgm_pkg::DEFAULT_MAX_VERTICES,
   parameter int MAX_EDGES    = tsgm_pkg::DEFAULT_MAX_EDGES
) (
   input  logic                      clock,
   input  logic                      reset,
   input  tsgm_pkg::req_type         req_item,
   input  tsgm_pkg::cmd_type         cmd,
   output tsgm_pkg::stat_type        stat,
   input  logic                      cfg_we,
   input  logic [tsgm_pkg::VID_W-1:0] cfg_wdata,
   output logic [tsgm_pkg::VID_W-1:0] vertex_count,
   output tsgm_pkg::rsp_type         rsp_item
);

   localparam int VW  = tsgm_pkg::VID_W;
   localparam int SW  = tsgm_pkg::SLOT_W;
   localparam int WW  = tsgm_pkg::WT_W;
   localparam int RAW = $clog2(MAX_VERTICES + 2);
   localparam int SAW = $clog2(MAX_VERTICES + 1);
   localparam int EAW = $clog2(MAX_EDGES);
   localparam int EDW = $bits(tsgm_pkg::edge_type);
   localparam int SDW = $bits(tsgm_pkg::suitor_type);

   logic [VW-1:0]  vc_ff, vc_in;
   logic [SAW-1:0] clr_addr_ff, clr_addr_in;
   logic [VW-1:0]  v_ff, v_in, cur_ff, cur_in, mate_ff, mate_in;
   logic           second_ff, second_in, found_ff, found_in;
   logic [SW-1:0]  lo_ff, lo_in, hi_ff, hi_in, e_ff, e_in;
   logic [WW-1:0]  heavy_ff, heavy_in;
   logic           rd_bad_ff, rd_bad_in;
   tsgm_pkg::rsp_type rsp_ff, rsp_in;

   logic [VW-1:0]  n_eff;
   logic [VW:0]    cur_next, v_next;
   logic [SW-1:0]  row_q;
   tsgm_pkg::edge_type   edge_q;
   tsgm_pkg::suitor_type suit_q, suit_new, suit_wdata;

   logic           row_we, row_re, edge_we, suit_we, suit_re, take, is_read, load_bad;
   logic [RAW-1:0] row_raddr;
   logic [SAW-1:0] suit_raddr, suit_waddr;

   // vertex count above the store size acts as the store size
   always_comb begin
      if (32'(vc_ff) > MAX_VERTICES) begin
         n_eff = VW'(MAX_VERTICES);
      end else begin
         n_eff = vc_ff;
      end
   end

   assign cur_next = {1'b0, cur_ff} + {{VW{1'b0}}, 1'b1};
   assign v_next   = {1'b0, v_ff} + {{VW{1'b0}}, 1'b1};
   assign is_read  = cmd.accept && (req_item.action == tsgm_pkg::ACT_READ);

   // ---------------- stores ----------------
   assign row_we    = cmd.accept && (req_item.action == tsgm_pkg::ACT_ROW) &&
                      (32'(req_item.slot) <= MAX_VERTICES + 1);
   assign row_re    = cmd.row_rd_lo || cmd.row_rd_hi;
   assign row_raddr = cmd.row_rd_hi ? RAW'(cur_next) : RAW'(cur_ff);

   tsgm_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES + 2)) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (RAW'(req_item.slot)),
      .wr_data (req_item.row_value),
      .rd_en   (row_re),
      .rd_addr (row_raddr),
      .rd_data (row_q)
   );

   assign edge_we = cmd.accept && (req_item.action == tsgm_pkg::ACT_EDGE) &&
                    (32'(req_item.slot) < MAX_EDGES);

   tsgm_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (EAW'(req_item.slot)),
      .wr_data ({req_item.neighbor, req_item.edge_weight_in}),
      .rd_en   (cmd.edge_rd),
      .rd_addr (EAW'(e_ff)),
      .rd_data (edge_q)
   );

   assign suit_we    = cmd.clr_step || cmd.mate_wr;
   assign suit_waddr = cmd.clr_step ? clr_addr_ff : SAW'(mate_ff);
   assign suit_wdata = cmd.clr_step ? '0 : suit_new;
   assign suit_re    = is_read || cmd.suit_rd || cmd.mate_rd;

   always_comb begin
      if (cmd.suit_rd) begin
         suit_raddr = SAW'(edge_q.target);
      end else if (cmd.mate_rd) begin
         suit_raddr = SAW'(mate_ff);
      end else begin
         suit_raddr = SAW'(req_item.slot);
      end
   end

   tsgm_ram #(.WIDTH(SDW), .DEPTH(MAX_VERTICES + 1)) u_suit_ram (
      .clock   (clock),
      .wr_en   (suit_we),
      .wr_addr (suit_waddr),
      .wr_data (suit_wdata),
      .rd_en   (suit_re),
      .rd_addr (suit_raddr),
      .rd_data (suit_q)
   );

   // ---------------- proposal logic ----------------
   // candidate edge check against the best edge so far and the neighbor's suitors
   always_comb begin
      take = 1'b1;
      if (found_ff && (edge_q.weight < heavy_ff)) take = 1'b0;
      if (suit_q.ru_w > edge_q.weight) take = 1'b0;
      if ((suit_q.best_s == cur_ff) || (suit_q.ru_s == cur_ff)) take = 1'b0;
      if (found_ff && (edge_q.weight == heavy_ff) && (edge_q.target < mate_ff)) take = 1'b0;
      if ((edge_q.weight == suit_q.ru_w) && (cur_ff < suit_q.ru_s)) take = 1'b0;
   end

   // place the proposal as best or runner-up at the chosen mate
   always_comb begin
      if ((suit_q.best_w < heavy_ff) ||
          ((suit_q.best_w == heavy_ff) && (suit_q.best_s < cur_ff))) begin
         suit_new.best_s = cur_ff;
         suit_new.best_w = heavy_ff;
         suit_new.ru_s   = suit_q.best_s;
         suit_new.ru_w   = suit_q.best_w;
      end else begin
         suit_new.best_s = suit_q.best_s;
         suit_new.best_w = suit_q.best_w;
         suit_new.ru_s   = cur_ff;
         suit_new.ru_w   = heavy_ff;
      end
   end

   always_comb begin
      vc_in       = vc_ff;
      clr_addr_in = clr_addr_ff;
      v_in        = v_ff;
      cur_in      = cur_ff;
      second_in   = second_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      e_in        = e_ff;
      found_in    = found_ff;
      heavy_in    = heavy_ff;
      mate_in     = mate_ff;
      rd_bad_in   = rd_bad_ff;
      if (cfg_we) vc_in = cfg_wdata;
      if (cmd.clr_start) clr_addr_in = '0;
      if (cmd.clr_step) clr_addr_in = clr_addr_ff + SAW'(1);
      if (cmd.run_init) begin
         v_in      = VW'(1);
         cur_in    = VW'(1);
         second_in = 1'b0;
      end
      if (cmd.row_rd_hi) lo_in = row_q;
      if (cmd.scan_init) begin
         e_in     = lo_ff;
         found_in = 1'b0;
         heavy_in = '0;
         mate_in  = '0;
         if (32'(row_q) > MAX_EDGES) begin
            hi_in = SW'(MAX_EDGES);
         end else begin
            hi_in = row_q;
         end
      end
      if (cmd.eval && take) begin
         found_in = 1'b1;
         heavy_in = edge_q.weight;
         mate_in  = edge_q.target;
      end
      if (cmd.eval || cmd.edge_skip) e_in = e_ff + SW'(1);
      if (cmd.mate_wr) cur_in = suit_q.ru_s;
      // cur may hold a bumped vertex here; the walk order follows v
      if (cmd.next_prop) begin
         if (!second_ff) begin
            second_in = 1'b1;
            cur_in    = v_ff;
         end else begin
            second_in = 1'b0;
            v_in      = VW'(v_next);
            cur_in    = VW'(v_next);
         end
      end
      if (is_read) rd_bad_in = 32'(req_item.slot) > MAX_VERTICES;
   end

   // ---------------- result register ----------------
   always_comb begin
      if (req_item.action == tsgm_pkg::ACT_ROW) begin
         load_bad = 32'(req_item.slot) > MAX_VERTICES + 1;
      end else begin
         load_bad = 32'(req_item.slot) >= MAX_EDGES;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.accept) begin
         rsp_in        = '0;
         rsp_in.status = load_bad;
      end
      if (cmd.rsp_read) begin
         rsp_in        = '0;
         rsp_in.status = rd_bad_ff;
         if (!rd_bad_ff) begin
            rsp_in.out_first_suitor  = suit_q.best_s;
            rsp_in.out_first_weight  = suit_q.best_w;
            rsp_in.out_second_suitor = suit_q.ru_s;
            rsp_in.out_second_weight = suit_q.ru_w;
         end
      end
      if (cmd.rsp_run) rsp_in = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff       <= tsgm_pkg::VERTEX_COUNT_RESET;
         clr_addr_ff <= '0;
      end else begin
         vc_ff       <= vc_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff      <= v_in;
      cur_ff    <= cur_in;
      second_ff <= second_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      e_ff      <= e_in;
      found_ff  <= found_in;
      heavy_ff  <= heavy_in;
      mate_ff   <= mate_in;
      rd_bad_ff <= rd_bad_in;
      rsp_ff    <= rsp_in;
   end

   assign stat.clr_last    = (clr_addr_ff == SAW'(MAX_VERTICES));
   assign stat.n_zero      = (n_eff == '0);
   assign stat.scan_done   = !(e_ff < hi_ff);
   assign stat.y_ok        = (edge_q.target != '0) && (edge_q.target <= n_eff);
   assign stat.prop_none   = !found_ff || (heavy_ff == '0);
   assign stat.bumped_zero = (suit_q.ru_s == '0);
   assign stat.run_last    = second_ff && (v_ff == n_eff);

   assign vertex_count = vc_ff;
   assign rsp_item     = rsp_ff;

endmodule

// ----- design/tsgm_ctrl.sv -----
// Controller: handshake and sequencing of loads, reads, clearing and proposals
module tsgm_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [tsgm_pkg::ACT_W-1:0]  req_action,
   output logic                        req_stall,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output tsgm_pkg::cmd_type           cmd,
   input  tsgm_pkg::stat_type          stat
);

   localparam logic [3:0] S_RST_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE      = 4'd1;
   localparam logic [3:0] S_RD_WAIT   = 4'd2;
   localparam logic [3:0] S_RUN_CLR   = 4'd3;
   localparam logic [3:0] S_ROW_LO    = 4'd4;
   localparam logic [3:0] S_ROW_HI    = 4'd5;
   localparam logic [3:0] S_SCAN_INIT = 4'd6;
   localparam logic [3:0] S_SCAN      = 4'd7;
   localparam logic [3:0] S_EDGE_W    = 4'd8;
   localparam logic [3:0] S_SUIT_W    = 4'd9;
   localparam logic [3:0] S_MATE_W    = 4'd10;
   localparam logic [3:0] S_NEXT      = 4'd11;
   localparam logic [3:0] S_RUN_DONE  = 4'd12;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       can_accept, acc, rsp_set;

   // the result register drains in the same cycle a new item enters
   assign can_accept = (state_ff == S_IDLE) && (!rsp_valid_ff || !rsp_stall);
   assign acc        = req_valid && can_accept;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      rsp_set  = 1'b0;
      case (state_ff)
         S_RST_CLR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (acc) begin
               cmd.accept = 1'b1;
               case (req_action)
                  tsgm_pkg::ACT_ROW, tsgm_pkg::ACT_EDGE: begin
                     rsp_set = 1'b1;
                  end
                  tsgm_pkg::ACT_RUN: begin
                     cmd.clr_start = 1'b1;
                     state_in      = S_RUN_CLR;
                  end
                  default: begin
                     state_in = S_RD_WAIT;
                  end
               endcase
            end
         end
         S_RD_WAIT: begin
            cmd.rsp_read = 1'b1;
            rsp_set      = 1'b1;
            state_in     = S_IDLE;
         end
         S_RUN_CLR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               if (stat.n_zero) begin
                  state_in = S_RUN_DONE;
               end else begin
                  cmd.run_init = 1'b1;
                  state_in     = S_ROW_LO;
               end
            end
         end
         S_ROW_LO: begin
            cmd.row_rd_lo = 1'b1;
            state_in      = S_ROW_HI;
         end
         S_ROW_HI: begin
            cmd.row_rd_hi = 1'b1;
            state_in      = S_SCAN_INIT;
         end
         S_SCAN_INIT: begin
            cmd.scan_init = 1'b1;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            if (stat.scan_done) begin
               if (stat.prop_none) begin
                  state_in = S_NEXT;
               end else begin
                  cmd.mate_rd = 1'b1;
                  state_in    = S_MATE_W;
               end
            end else begin
               cmd.edge_rd = 1'b1;
               state_in    = S_EDGE_W;
            end
         end
         S_EDGE_W: begin
            if (stat.y_ok) begin
               cmd.suit_rd = 1'b1;
               state_in    = S_SUIT_W;
            end else begin
               cmd.edge_skip = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SUIT_W: begin
            cmd.eval = 1'b1;
            state_in = S_SCAN;
         end
         S_MATE_W: begin
            cmd.mate_wr = 1'b1;
            // a displaced runner-up proposes again right away
            if (stat.bumped_zero) begin
               state_in = S_NEXT;
            end else begin
               state_in = S_ROW_LO;
            end
         end
         S_NEXT: begin
            if (stat.run_last) begin
               state_in = S_RUN_DONE;
            end else begin
               cmd.next_prop = 1'b1;
               state_in      = S_ROW_LO;
            end
         end
         S_RUN_DONE: begin
            cmd.rsp_run = 1'b1;
            rsp_set     = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (rsp_set) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_RST_CLR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = !can_accept;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- design/two_suitor_graph_matching.sv -----
// Two-suitor graph matching: top level
// Usage:
//   req channel (req_valid / req_stall / req_item) takes one item per action:
//   row-start load, edge load, run, or vertex read. rsp channel (rsp_valid /
//   rsp_stall / rsp_item) returns exactly one result item per request item.
//   The vertex_count register sits at byte address 0 of the APB-style port.
// Sequencing:
//   Loads answer in the cycle after acceptance and may arrive every cycle
//   while rsp_stall is low. A read answers after a read-wait state; no new
//   item is taken before that. A run first clears the suitor store, then
//   walks each proposer's row: the row bounds, each edge (edge store read,
//   then suitor store read), then a mate read and write to place a proposal;
//   every vertex proposes twice, and displaced runner-ups propose again.
// Reset: a clearing pass zeroes every slot of the suitor store;
//   req_stall stays high during it. Graph stores are undefined until loaded.
// Stall: a pending result is held in the output register while rsp_stall is
//   high; no new item is taken until that result can leave.
module two_suitor_graph_matching #(
   parameter int MAX_VERTICES = tsgm_pkg::DEFAULT_MAX_VERTICES,
   parameter int MAX_EDGES    = tsgm_pkg::DEFAULT_MAX_EDGES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  tsgm_pkg::req_type            req_item,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output tsgm_pkg::rsp_type            rsp_item,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tsgm_pkg::CSR_AW-1:0]  paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);

   tsgm_pkg::cmd_type  cmd;
   tsgm_pkg::stat_type stat;
   logic                       cfg_we;
   logic [tsgm_pkg::VID_W-1:0] vertex_count;

   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite && (paddr[2] == tsgm_pkg::REG_VERTEX_COUNT);
   assign prdata = (paddr[2] == tsgm_pkg::REG_VERTEX_COUNT) ?
                   {{(32 - tsgm_pkg::VID_W){1'b0}}, vertex_count} : 32'd0;

   tsgm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_item.action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .stat       (stat)
   );

   tsgm_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .MAX_EDGES    (MAX_EDGES)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_item     (req_item),
      .cmd          (cmd),
      .stat         (stat),
      .cfg_we       (cfg_we),
      .cfg_wdata    (pwdata[tsgm_pkg::VID_W-1:0]),
      .vertex_count (vertex_count),
      .rsp_item     (rsp_item)
   );

endmodule

// ----- design/tsgm_checker.sv -----
// Port-level checker for the two-suitor matching block, with its bind
`include "two_suitor_graph_matching_assert.svh"

module tsgm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input tsgm_pkg::req_type           req_item,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input tsgm_pkg::rsp_type           rsp_item
);

   `TSGM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_item), "result item changed while stalled")

   `TSGM_ASSERT_NEXT(a_load_answer, clock, reset, req_valid && !req_stall && (req_item.action == tsgm_pkg::ACT_ROW || req_item.action == tsgm_pkg::ACT_EDGE), rsp_valid, "load item not answered in the next cycle")

   `TSGM_ASSERT_NOW(a_reset_clear, clock, reset, $past(reset), req_stall && !rsp_valid, "block not clearing after reset")

   `TSGM_ASSERT_NOW(a_empty_suitor, clock, reset, rsp_valid && (rsp_item.out_first_suitor == '0), (rsp_item.out_first_weight == '0) && (rsp_item.out_second_suitor == '0) && (rsp_item.out_second_weight == '0), "weight reported without a suitor")

endmodule

bind two_suitor_graph_matching tsgm_checker u_tsgm_checker (.*);

// ----- dv/two_suitor_graph_matching_checker.sv -----
// Watches both channels and the register port, predicts every result and compares
`timescale 1ns / 1ps

module two_suitor_graph_matching_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  tsgm_pkg::req_type                   req_item,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  tsgm_pkg::rsp_type                   rsp_item,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tsgm_pkg::CSR_AW-1:0]         paddr,
   input  logic [31:0]                         pwdata,
   input  logic [31:0]                         prdata,
   input  logic                                pready,
   output int                                  fail_count,
   output int                                  pending
);

   localparam int NV = tsgm_pkg::DEFAULT_MAX_VERTICES;
   localparam int NE = tsgm_pkg::DEFAULT_MAX_EDGES;
   localparam int VW = tsgm_pkg::VID_W;
   localparam int WW = tsgm_pkg::WT_W;

   logic [VW-1:0]               vcount;
   logic [tsgm_pkg::SLOT_W-1:0] row_start_mem [0:NV+1];
   logic [VW-1:0]               edge_dst      [0:NE-1];
   logic [WW-1:0]               edge_wt       [0:NE-1];
   logic [VW-1:0]               first_s       [0:NV];
   logic [WW-1:0]               first_w       [0:NV];
   logic [VW-1:0]               second_s      [0:NV];
   logic [WW-1:0]               second_w      [0:NV];
   tsgm_pkg::rsp_type           expected_rsp [$];

   assign pending = expected_rsp.size();

   function automatic void clear_suitors();
      for (int i = 0; i <= NV; i++) begin
         first_s[i] = '0;
         first_w[i] = '0;
         second_s[i] = '0;
         second_w[i] = '0;
      end
   endfunction

   // one proposal from v, followed by any chain of bumped runner-ups
   function automatic void propose(int v, int n);
      int cur, lo, hi, mate, bumped;
      bit found;
      logic [WW-1:0] heavy, w;
      int y;
      cur = v;
      forever begin
         found = 0;
         heavy = '0;
         mate = 0;
         lo = row_start_mem[cur];
         hi = row_start_mem[cur + 1];
         if (hi > NE) hi = NE;
         for (int e = lo; e < hi; e++) begin
            y = edge_dst[e];
            w = edge_wt[e];
            if (y == 0 || y > n) continue;
            if (found && w < heavy) continue;
            if (second_w[y] > w) continue;
            if (first_s[y] == cur || second_s[y] == cur) continue;
            if (found && w == heavy && y < mate) continue;
            if (w == second_w[y] && cur < second_s[y]) continue;
            found = 1;
            heavy = w;
            mate = y;
         end
         if (!found || heavy == 0) return;
         bumped = second_s[mate];
         if (first_w[mate] < heavy || (first_w[mate] == heavy && first_s[mate] < cur)) begin
            second_s[mate] = first_s[mate];
            second_w[mate] = first_w[mate];
            first_s[mate] = VW'(cur);
            first_w[mate] = heavy;
         end else begin
            second_s[mate] = VW'(cur);
            second_w[mate] = heavy;
         end
         if (bumped == 0) return;
         cur = bumped;
      end
   endfunction

   function automatic tsgm_pkg::rsp_type apply_item(tsgm_pkg::req_type it);
      tsgm_pkg::rsp_type r;
      int n;
      r = '0;
      case (it.action)
         tsgm_pkg::ACT_ROW: begin
            if (it.slot <= NV + 1) row_start_mem[it.slot] = it.row_value;
            else r.status = 1'b1;
         end
         tsgm_pkg::ACT_EDGE: begin
            if (it.slot < NE) begin
               edge_dst[it.slot] = it.neighbor;
               edge_wt[it.slot] = it.edge_weight_in;
            end else begin
               r.status = 1'b1;
            end
         end
         tsgm_pkg::ACT_RUN: begin
            n = (vcount > NV) ? NV : vcount;
            clear_suitors();
            for (int v = 1; v <= n; v++) begin
               propose(v, n);
               propose(v, n);
            end
         end
         default: begin
            if (it.slot <= NV) begin
               r.out_first_suitor = first_s[it.slot];
               r.out_first_weight = first_w[it.slot];
               r.out_second_suitor = second_s[it.slot];
               r.out_second_weight = second_w[it.slot];
            end else begin
               r.status = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      tsgm_pkg::rsp_type exp_r;
      if (reset) begin
         vcount = tsgm_pkg::VERTEX_COUNT_RESET;
         clear_suitors();
         expected_rsp.delete();
      end else begin
         if (psel && penable && !pwrite && pready &&
             paddr == (tsgm_pkg::CSR_AW'(tsgm_pkg::REG_VERTEX_COUNT) << 2)) begin
            if (prdata !== 32'(vcount)) begin
               $error("prdata: expected %0d, got %0d", vcount, prdata);
               fail_count++;
            end
         end
         if (psel && penable && pwrite && pready &&
             paddr == (tsgm_pkg::CSR_AW'(tsgm_pkg::REG_VERTEX_COUNT) << 2))
            vcount = pwdata[VW-1:0];
         if (req_valid && !req_stall)
            expected_rsp.push_back(apply_item(req_item));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $error("result item with nothing expected");
               fail_count++;
            end else begin
               exp_r = expected_rsp.pop_front();
               if (rsp_item.status !== exp_r.status) begin
                  $error("status: expected %0h, got %0h", exp_r.status, rsp_item.status);
                  fail_count++;
               end
               if (rsp_item.out_first_suitor !== exp_r.out_first_suitor) begin
                  $error("out_first_suitor: expected %0d, got %0d",
                         exp_r.out_first_suitor, rsp_item.out_first_suitor);
                  fail_count++;
               end
               if (rsp_item.out_first_weight !== exp_r.out_first_weight) begin
                  $error("out_first_weight: expected %0h, got %0h",
                         exp_r.out_first_weight, rsp_item.out_first_weight);
                  fail_count++;
               end
               if (rsp_item.out_second_suitor !== exp_r.out_second_suitor) begin
                  $error("out_second_suitor: expected %0d, got %0d",
                         exp_r.out_second_suitor, rsp_item.out_second_suitor);
                  fail_count++;
               end
               if (rsp_item.out_second_weight !== exp_r.out_second_weight) begin
                  $error("out_second_weight: expected %0h, got %0h",
                         exp_r.out_second_weight, rsp_item.out_second_weight);
                  fail_count++;
               end
            end
         end
      end
   end

   initial fail_count = 0;

endmodule

// ----- dv/tb_top.sv -----
// Stimulus, clock, reset and verdict for the two-suitor matching block
`timescale 1ns / 1ps

module tb_top;

   localparam int NV = tsgm_pkg::DEFAULT_MAX_VERTICES;
   localparam int NE = tsgm_pkg::DEFAULT_MAX_EDGES;
   localparam int WW = tsgm_pkg::WT_W;
   localparam int IDLE_LIMIT = 100000;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_stall;
   tsgm_pkg::req_type           req_item;
   logic                        rsp_valid;
   logic                        rsp_stall;
   tsgm_pkg::rsp_type           rsp_item;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [tsgm_pkg::CSR_AW-1:0] paddr;
   logic [31:0]                 pwdata;
   logic [31:0]                 prdata;
   logic                        pready;
   int                          fail_count;
   int                          pending;

   bit quiet;
   int items_sent;
   int runs_done;
   int results_seen;
   int idle_cycles;

   two_suitor_graph_matching i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   two_suitor_graph_matching_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   // watchdog on cycles in which no item moves on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
         end
      end
      if (!reset && rsp_valid && !rsp_stall) results_seen <= results_seen + 1;
   end

   // receiver: random stall bursts, one long hold-off so the block backs up
   initial begin
      int hold;
      bit held_long;
      hold = 0;
      held_long = 0;
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1;
         end else if (!held_long && results_seen >= 60) begin
            held_long = 1;
            hold = 400;
            rsp_stall <= 1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(0, 16);
            rsp_stall <= 1;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   function automatic tsgm_pkg::req_type mk(logic [tsgm_pkg::ACT_W-1:0] a, int slot,
                                            int rv = 0, int nb = 0,
                                            logic [WW-1:0] w = '0);
      tsgm_pkg::req_type it;
      it.action = a;
      it.slot = tsgm_pkg::SLOT_W'(slot);
      it.row_value = tsgm_pkg::SLOT_W'(rv);
      it.neighbor = tsgm_pkg::VID_W'(nb);
      it.edge_weight_in = w;
      return it;
   endfunction

   function automatic logic [WW-1:0] pick_weight();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return $urandom();
         default: return WW'($urandom_range(1, 3)) << 16;
      endcase
   endfunction

   task automatic send(tsgm_pkg::req_type it);
      int gap;
      @(negedge clock);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1;
      req_item <= it;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (it.action == tsgm_pkg::ACT_RUN) runs_done++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // register write, then a read back of the same register
   task automatic write_vertex_count(int value);
      drain();
      psel <= 1;
      pwrite <= 1;
      paddr <= tsgm_pkg::CSR_AW'(tsgm_pkg::REG_VERTEX_COUNT) << 2;
      pwdata <= 32'(value);
      @(negedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      penable <= 0;
      pwrite <= 0;
      @(negedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 0;
      penable <= 0;
   endtask

   // loads, reads and out-of-range slots; never a run
   task automatic send_noise(int count);
      int k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(0, 2);
         if (k == 0)
            send(mk(tsgm_pkg::ACT_ROW, $urandom_range(0, 16383), $urandom_range(0, 16383)));
         else if (k == 1)
            send(mk(tsgm_pkg::ACT_EDGE, $urandom_range(0, 16383), 0,
                    $urandom_range(0, 2047), $urandom()));
         else
            send(mk(tsgm_pkg::ACT_READ, $urandom_range(0, 16383)));
      end
   endtask

   // graph on rows 1..n+1, some row starts falling; every edge any row can reach is written
   task automatic load_graph(int n, int base, int maxdeg, bit past_store);
      int s [0:NV+1];
      int top_edge;
      s[1] = base;
      top_edge = base;
      for (int v = 1; v <= n; v++) begin
         if ($urandom_range(0, 7) == 0 && s[v] > base) s[v+1] = s[v] - 1;
         else s[v+1] = s[v] + $urandom_range(0, maxdeg);
      end
      if (past_store) s[n+1] = NE + 8;
      for (int v = 1; v <= n + 1; v++) begin
         send(mk(tsgm_pkg::ACT_ROW, v, s[v]));
         if (s[v] > top_edge) top_edge = s[v];
      end
      if (top_edge > NE) top_edge = NE;
      for (int e = base; e < top_edge; e++)
         send(mk(tsgm_pkg::ACT_EDGE, e, 0,
                 ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047)
                                             : $urandom_range(0, n + 1),
                 pick_weight()));
   endtask

   task automatic read_back(int n);
      for (int i = 0; i < n + 4; i++)
         send(mk(tsgm_pkg::ACT_READ, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16383)
                                                                 : $urandom_range(0, n + 1)));
   endtask

   task automatic phase(int reg_value, int base, int maxdeg, bit past_store, bit reload);
      int n;
      n = (reg_value > NV) ? NV : reg_value;
      write_vertex_count(reg_value);
      if (reload) begin
         send_noise($urandom_range(3, 10));
         load_graph(n, base, maxdeg, past_store);
      end
      send(mk(tsgm_pkg::ACT_RUN, $urandom_range(0, 16383), $urandom_range(0, 16383),
              $urandom_range(0, 2047), $urandom()));
      read_back(n > 40 ? 40 : n);
   endtask

   initial begin
      int nv;
      reset = 1;
      req_valid = 0;
      req_item = '0;
      psel = 0;
      penable = 0;
      pwrite = 0;
      paddr = '0;
      pwdata = '0;
      quiet = 0;
      items_sent = 0;
      runs_done = 0;
      results_seen = 0;
      idle_cycles = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: slot limits, field extremes, empty run
      send(mk(tsgm_pkg::ACT_READ, 0));
      send(mk(tsgm_pkg::ACT_READ, NV));
      send(mk(tsgm_pkg::ACT_READ, NV + 1));
      send(mk(tsgm_pkg::ACT_READ, 16383));
      send(mk(tsgm_pkg::ACT_ROW, NV + 1, 16383));
      send(mk(tsgm_pkg::ACT_ROW, NV + 2, 5));
      send(mk(tsgm_pkg::ACT_ROW, 16383, 16383));
      send(mk(tsgm_pkg::ACT_ROW, 0, 16383));
      send(mk(tsgm_pkg::ACT_EDGE, NE - 1, 0, 2047, '1));
      send(mk(tsgm_pkg::ACT_EDGE, NE, 0, 3, '1));
      send(mk(tsgm_pkg::ACT_EDGE, 16383, 0, 2047, '1));
      send(mk(tsgm_pkg::ACT_EDGE, 0, 0, 0, '0));
      write_vertex_count(0);
      send(mk(tsgm_pkg::ACT_RUN, 0));
      send(mk(tsgm_pkg::ACT_READ, 1));
      // triangle with equal weights: ties by index, bumped runner-ups
      write_vertex_count(3);
      send(mk(tsgm_pkg::ACT_ROW, 1, 0));
      send(mk(tsgm_pkg::ACT_ROW, 2, 2));
      send(mk(tsgm_pkg::ACT_ROW, 3, 4));
      send(mk(tsgm_pkg::ACT_ROW, 4, 6));
      send(mk(tsgm_pkg::ACT_EDGE, 0, 0, 2, 32'h0001_0000));
      send(mk(tsgm_pkg::ACT_EDGE, 1, 0, 3, 32'h0001_0000));
      send(mk(tsgm_pkg::ACT_EDGE, 2, 0, 1, 32'h0001_0000));
      send(mk(tsgm_pkg::ACT_EDGE, 3, 0, 3, 32'h0001_0000));
      send(mk(tsgm_pkg::ACT_EDGE, 4, 0, 1, 32'h0001_0000));
      send(mk(tsgm_pkg::ACT_EDGE, 5, 0, 2, 32'h0001_0000));
      send(mk(tsgm_pkg::ACT_RUN, 0));
      read_back(3);

      // random graphs, mostly small
      for (int p = 0; p < 13; p++) begin
         nv = $urandom_range(1, 12);
         phase(nv, $urandom_range(0, NE - 64), $urandom_range(1, 5), 0, 1);
      end
      phase(4, NE - 6, 3, 1, 1);
      phase(1, $urandom_range(0, 100), 3, 0, 1);
      quiet = 1;
      for (int p = 0; p < 3; p++)
         phase($urandom_range(2, 10), $urandom_range(0, NE - 64), 4, 0, 1);

      drain();
      repeat (20) @(posedge clock);
      $display("Ran %0d items, %0d matching runs, on graphs of 0 to 12 vertices,",
               items_sent, runs_done);
      $display("with load and read slots past both ends of the stores.");
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- two_suitor_graph_matching.f -----
+incdir+design
design/tsgm_pkg.sv
design/tsgm_ram.sv
design/tsgm_datapath.sv
design/tsgm_ctrl.sv
design/two_suitor_graph_matching.sv
design/tsgm_checker.sv
dv/two_suitor_graph_matching_checker.sv
dv/tb_top.sv
